[rtl/lcr_pkg.sv]
package lcr_pkg;

  // Default coordinate width of the segment and window fields.
  localparam int COORD_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 8'd3;

  // Window reset values.
  localparam int RESET_LEFT   = 0;
  localparam int RESET_TOP    = 0;
  localparam int RESET_RIGHT  = 1023;
  localparam int RESET_BOTTOM = 767;

  // Outcome of the parameter compare, carried down the pipeline.
  typedef struct packed {
    logic visible;
    logic start_tight;
    logic end_tight;
  } clip_flags_t;

endpackage

[rtl/lcr_axis.sv]
// One axis of the parametric test: both window edges of that axis give an
// entering and a leaving parameter over the common denominator |delta|.
module lcr_axis #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic signed [COORD_BITS-1:0] p_start,
  input  logic signed [COORD_BITS-1:0] p_end,
  input  logic signed [COORD_BITS-1:0] lim_lo,
  input  logic signed [COORD_BITS-1:0] lim_hi,
  output logic        [COORD_BITS-1:0] den_r,
  output logic        [COORD_BITS-1:0] mag_r,
  output logic                         neg_r,
  output logic signed [COORD_BITS:0]   enter_r,
  output logic signed [COORD_BITS:0]   leave_r,
  output logic                         ok_r
);
  localparam int C = COORD_BITS;

  logic signed [C:0] s_ext, e_ext, lo_ext, hi_ext;
  logic signed [C:0] delta, mag_full, raw_en, raw_ln, den_s;
  logic              par, outside;
  logic [C-1:0]      den_nxt, mag_nxt;
  logic              neg_nxt, ok_nxt;
  logic signed [C:0] enter_nxt, leave_nxt;

  // Entering numerator clamped below at 0, leaving numerator clamped above at the denominator |delta|.
  always_comb begin
    s_ext    = {p_start[C-1], p_start};
    e_ext    = {p_end[C-1], p_end};
    lo_ext   = {lim_lo[C-1], lim_lo};
    hi_ext   = {lim_hi[C-1], lim_hi};
    delta    = e_ext - s_ext;
    neg_nxt  = delta[C];
    mag_full = neg_nxt ? -delta : delta;
    mag_nxt  = mag_full[C-1:0];
    par      = (delta == '0);
    outside  = (s_ext < lo_ext) || (s_ext > hi_ext);
    raw_en   = neg_nxt ? (s_ext - hi_ext) : (lo_ext - s_ext);
    raw_ln   = neg_nxt ? (s_ext - lo_ext) : (hi_ext - s_ext);
    den_s    = $signed({1'b0, mag_nxt});
    if (par) begin
      den_nxt   = C'(1);
      enter_nxt = '0;
      leave_nxt = (C+1)'(1);
      ok_nxt    = !outside;
    end else begin
      den_nxt   = mag_nxt;
      enter_nxt = (raw_en < 0) ? '0 : raw_en;
      leave_nxt = (raw_ln > den_s) ? den_s : raw_ln;
      ok_nxt    = (enter_nxt <= leave_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r   <= den_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      enter_r <= enter_nxt;
      leave_r <= leave_nxt;
      ok_r    <= ok_nxt;
    end
  end

endmodule

[rtl/lcr_select.sv]
// Cross products between the axes, then the largest entering and the
// smallest leaving parameter and the visibility decision.
module lcr_select #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic                         ok_x,
  input  logic                         ok_y,
  input  logic signed [COORD_BITS:0]   enter_x,
  input  logic signed [COORD_BITS:0]   leave_x,
  input  logic        [COORD_BITS-1:0] den_x,
  input  logic signed [COORD_BITS:0]   enter_y,
  input  logic signed [COORD_BITS:0]   leave_y,
  input  logic        [COORD_BITS-1:0] den_y,
  output logic        [COORD_BITS-1:0] en_num_r,
  output logic        [COORD_BITS-1:0] en_den_r,
  output logic        [COORD_BITS-1:0] lv_num_r,
  output logic        [COORD_BITS-1:0] lv_den_r,
  output lcr_pkg::clip_flags_t         flags_r
);
  localparam int C = COORD_BITS;
  localparam int PW = 2 * C + 2;

  logic signed [2*C+1:0] pe_x_r, pe_y_r, pl_x_r, pl_y_r;
  logic signed [C:0]     ex_r, ey_r, lx_r, ly_r;
  logic [C-1:0]          dx_r, dy_r;
  logic                  ok_r;

  logic signed [C:0]     en_ch, lv_ch;
  logic [C-1:0]          ed_ch, ld_ch;
  logic [C-1:0]          en_num_nxt, en_den_nxt, lv_num_nxt, lv_den_nxt;
  lcr_pkg::clip_flags_t  flags_nxt;

  // First stage: each parameter multiplied by the other axis' denominator.
  always_ff @(posedge clk) begin
    if (adv) begin
      pe_x_r <= PW'(enter_x) * PW'($signed({1'b0, den_y}));
      pe_y_r <= PW'(enter_y) * PW'($signed({1'b0, den_x}));
      pl_x_r <= PW'(leave_x) * PW'($signed({1'b0, den_y}));
      pl_y_r <= PW'(leave_y) * PW'($signed({1'b0, den_x}));
      ex_r   <= enter_x;
      ey_r   <= enter_y;
      lx_r   <= leave_x;
      ly_r   <= leave_y;
      dx_r   <= den_x;
      dy_r   <= den_y;
      ok_r   <= ok_x && ok_y;
    end
  end

  // Second stage: pick the tightest pair and check it is not empty.
  always_comb begin
    if (pe_y_r > pe_x_r) begin
      en_ch = ey_r;
      ed_ch = dy_r;
    end else begin
      en_ch = ex_r;
      ed_ch = dx_r;
    end
    if (pl_y_r < pl_x_r) begin
      lv_ch = ly_r;
      ld_ch = dy_r;
    end else begin
      lv_ch = lx_r;
      ld_ch = dx_r;
    end
    en_num_nxt            = en_ch[C-1:0];
    en_den_nxt            = ed_ch;
    lv_num_nxt            = lv_ch[C-1:0];
    lv_den_nxt            = ld_ch;
    flags_nxt.visible     = ok_r && (pe_x_r <= pl_y_r) && (pe_y_r <= pl_x_r);
    flags_nxt.start_tight = (en_ch != '0);
    flags_nxt.end_tight   = (lv_ch < $signed({1'b0, ld_ch}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      en_num_r <= en_num_nxt;
      en_den_r <= en_den_nxt;
      lv_num_r <= lv_num_nxt;
      lv_den_r <= lv_den_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

[rtl/lcr_div.sv]
// Scaled offset round(mag * num / den), halves up, as one product stage
// followed by one restoring division stage per quotient bit.
module lcr_div #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] num,
  input  logic [COORD_BITS-1:0] den,
  output logic [COORD_BITS-1:0] quot
);
  localparam int C  = COORD_BITS;
  localparam int RW = 2 * C + 2;

  logic [RW-1:0]  rem_r [0:C];
  logic [C-1:0]   den_r [0:C];
  logic [C-1:0]   q_r   [0:C];
  logic [2*C-1:0] prod;

  // Full-width product of the offset magnitude and the parameter numerator.
  assign prod = (2*C)'(mag) * (2*C)'(num);

  // Numerator 2*mag*num + den over divisor 2*den gives the rounded quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= RW'({prod, 1'b0}) + RW'(den);
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < C; k++) begin : g_step
    localparam int BIT = C - 1 - k;
    logic [RW-1:0] sub;
    logic          take;
    logic [RW-1:0] rem_nxt;
    logic [C-1:0]  q_nxt;

    always_comb begin
      sub     = RW'(den_r[k]) << (BIT + 1);
      take    = (rem_r[k] >= sub);
      rem_nxt = take ? (rem_r[k] - sub) : rem_r[k];
      q_nxt   = q_r[k];
      q_nxt[BIT] = take;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= q_nxt;
      end
    end
  end

  assign quot = q_r[C];

endmodule

[rtl/line_clip_rectangle.sv]
// An accepted request passes the input register, the axis, select and divider
// stages and the output register. Throughput: one segment per cycle; the
// divider pipeline of one stage per quotient bit sets the depth. A stalled
// output halts the whole pipeline. Reset (rst_n low, synchronous) empties
// the pipeline and loads the window with left 0, top 0, right 1023, bottom 767.
module line_clip_rectangle #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // x_start, y_start, x_end, y_end from bit 0 up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // clip_x_start, clip_y_start, clip_x_end, clip_y_end from bit 0 up
  output logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // visible
  output logic                          out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data
);
  localparam int C     = COORD_BITS;
  localparam int DW    = ((4 * C + 7) / 8) * 8;
  localparam int LAST  = C + 4;

  logic signed [C-1:0] left_r, top_r, right_r, bottom_r;
  logic                adv;

  logic [LAST:0]       v_r;
  logic [4*C-1:0]      crd_r [1:LAST];
  logic [1:0]          neg_r [2:LAST];
  logic [2*C-1:0]      mag_r [2:3];
  lcr_pkg::clip_flags_t flg_r [4:LAST];
  logic [4*C-1:0]      in_r;

  logic [C-1:0]        den_x, den_y, mag_x, mag_y;
  logic                neg_x, neg_y, ok_x, ok_y;
  logic signed [C:0]   en_x, lv_x, en_y, lv_y;
  logic [C-1:0]        en_num, en_den, lv_num, lv_den;
  lcr_pkg::clip_flags_t sel_flags;
  logic [C-1:0]        q_sx, q_sy, q_ex, q_ey;

  logic [C-1:0]        x1, y1, x2, y2, sx, sy, ex, ey, off_sx, off_sy, off_ex, off_ey;
  logic [DW-1:0]       out_tdata_r, out_tdata_nxt;
  logic                out_tuser_r, out_tuser_nxt, out_tvalid_r;

  // Whole pipeline moves when the output register can take a result.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= C'(lcr_pkg::RESET_LEFT);
      top_r    <= C'(lcr_pkg::RESET_TOP);
      right_r  <= C'(lcr_pkg::RESET_RIGHT);
      bottom_r <= C'(lcr_pkg::RESET_BOTTOM);
    end else if (cfg_valid) begin
      case (cfg_index)
        lcr_pkg::REG_LEFT:   left_r   <= cfg_data;
        lcr_pkg::REG_TOP:    top_r    <= cfg_data;
        lcr_pkg::REG_RIGHT:  right_r  <= cfg_data;
        lcr_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:0], in_tvalid};
    end
  end

  // Input register and side data lines.
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r     <= in_tdata[4*C-1:0];
      crd_r[1] <= in_r;
      neg_r[2] <= {neg_y, neg_x};
      mag_r[2] <= {mag_y, mag_x};
      mag_r[3] <= mag_r[2];
      flg_r[4] <= sel_flags;
      for (int k = 2; k <= LAST; k++) begin
        crd_r[k] <= crd_r[k-1];
      end
      for (int k = 3; k <= LAST; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
      for (int k = 5; k <= LAST; k++) begin
        flg_r[k] <= flg_r[k-1];
      end
    end
  end

  lcr_axis #(.COORD_BITS(C)) u_axis_x (
    .clk(clk), .adv(adv),
    .p_start(in_r[0 +: C]), .p_end(in_r[2*C +: C]),
    .lim_lo(left_r), .lim_hi(right_r),
    .den_r(den_x), .mag_r(mag_x), .neg_r(neg_x),
    .enter_r(en_x), .leave_r(lv_x), .ok_r(ok_x)
  );

  lcr_axis #(.COORD_BITS(C)) u_axis_y (
    .clk(clk), .adv(adv),
    .p_start(in_r[C +: C]), .p_end(in_r[3*C +: C]),
    .lim_lo(top_r), .lim_hi(bottom_r),
    .den_r(den_y), .mag_r(mag_y), .neg_r(neg_y),
    .enter_r(en_y), .leave_r(lv_y), .ok_r(ok_y)
  );

  lcr_select #(.COORD_BITS(C)) u_select (
    .clk(clk), .adv(adv), .ok_x(ok_x), .ok_y(ok_y),
    .enter_x(en_x), .leave_x(lv_x), .den_x(den_x),
    .enter_y(en_y), .leave_y(lv_y), .den_y(den_y),
    .en_num_r(en_num), .en_den_r(en_den), .lv_num_r(lv_num), .lv_den_r(lv_den),
    .flags_r(sel_flags)
  );

  lcr_div #(.COORD_BITS(C)) u_div_sx (
    .clk(clk), .adv(adv), .mag(mag_r[3][0 +: C]), .num(en_num), .den(en_den),
    .quot(q_sx)
  );
  lcr_div #(.COORD_BITS(C)) u_div_sy (
    .clk(clk), .adv(adv), .mag(mag_r[3][C +: C]), .num(en_num), .den(en_den),
    .quot(q_sy)
  );
  lcr_div #(.COORD_BITS(C)) u_div_ex (
    .clk(clk), .adv(adv), .mag(mag_r[3][0 +: C]), .num(lv_num), .den(lv_den),
    .quot(q_ex)
  );
  lcr_div #(.COORD_BITS(C)) u_div_ey (
    .clk(clk), .adv(adv), .mag(mag_r[3][C +: C]), .num(lv_num), .den(lv_den),
    .quot(q_ey)
  );

  // Clipped endpoints: start point plus signed offset where tightened.
  always_comb begin
    x1     = crd_r[LAST][0 +: C];
    y1     = crd_r[LAST][C +: C];
    x2     = crd_r[LAST][2*C +: C];
    y2     = crd_r[LAST][3*C +: C];
    off_sx = neg_r[LAST][0] ? (~q_sx + C'(1)) : q_sx;
    off_sy = neg_r[LAST][1] ? (~q_sy + C'(1)) : q_sy;
    off_ex = neg_r[LAST][0] ? (~q_ex + C'(1)) : q_ex;
    off_ey = neg_r[LAST][1] ? (~q_ey + C'(1)) : q_ey;
    sx     = flg_r[LAST].start_tight ? (x1 + off_sx) : x1;
    sy     = flg_r[LAST].start_tight ? (y1 + off_sy) : y1;
    ex     = flg_r[LAST].end_tight ? (x1 + off_ex) : x2;
    ey     = flg_r[LAST].end_tight ? (y1 + off_ey) : y2;
    out_tuser_nxt = flg_r[LAST].visible;
    out_tdata_nxt = flg_r[LAST].visible ? DW'({ey, ex, sy, sx}) : '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  // A rejected segment carries zero coordinates.
  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r |-> out_tdata_r == '0)
    else $error("invisible result with nonzero coordinates");

  // A held output keeps the valid bits of every stage and the output data frozen.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r) && $stable(out_tdata_r))
    else $error("pipeline moved during a stall");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid_r)
    else $error("output valid right after reset");
`endif

endmodule
